// File: rtl/crg_pkg.sv
// ----------------------------------------------------------------------------
// crg_pkg
// Shared types, constants and helpers for the circular region grayscale block.
// ----------------------------------------------------------------------------
package crg_pkg;

  localparam int unsigned MaxWidth  = 1024;
  localparam int unsigned MaxHeight = 1024;

  // counter widths follow the largest frame
  localparam int unsigned ColW = $clog2(MaxWidth);
  localparam int unsigned RowW = $clog2(MaxHeight);

  // register widths
  localparam int unsigned CtrW = 10;
  localparam int unsigned RadW = 11;
  localparam int unsigned DimW = 11;

  localparam int unsigned ChanW  = 8;
  localparam int unsigned PixW   = 3 * ChanW;
  localparam int unsigned DataW  = 32;
  localparam int unsigned AddrW  = 5;

  // squared distance and squared radius
  localparam int unsigned DistW  = 2 * CtrW + 1;
  localparam int unsigned RadSqW = 2 * RadW;

  // luma weights in hundredths
  localparam int unsigned SumW     = 15;
  localparam int unsigned WeightR  = 30;
  localparam int unsigned WeightG  = 59;
  localparam int unsigned WeightB  = 11;
  // divide by 100: multiply by 5243 and shift right by 19, exact for sums up to 25500
  localparam int unsigned RecipW   = 13;
  localparam int unsigned Recip    = 5243;
  localparam int unsigned RecipSh  = 19;
  localparam int unsigned ProdW    = SumW + RecipW;

  typedef enum logic [2:0] {
    RegCenterX = 3'd0,
    RegCenterY = 3'd1,
    RegRadius  = 3'd2,
    RegWidth   = 3'd3,
    RegHeight  = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [CtrW-1:0] center_x;
    logic [CtrW-1:0] center_y;
    logic [RadW-1:0] radius;
    logic [DimW-1:0] image_width;
    logic [DimW-1:0] image_height;
  } cfg_t;

  // clamp a frame dimension to 1..maxv
  function automatic logic [DimW:0] clamp_dim(logic [DimW-1:0] v, logic [DimW:0] maxv);
    logic [DimW:0] r;
    begin
      if (v == '0) begin
        r = (DimW+1)'(1);
      end else if ({1'b0, v} > maxv) begin
        r = maxv;
      end else begin
        r = {1'b0, v};
      end
      return r;
    end
  endfunction

endpackage

// File: rtl/crg_apb_regs.sv
// ----------------------------------------------------------------------------
// crg_apb_regs
// APB register file holding circle centre, radius and frame dimensions.
// ----------------------------------------------------------------------------
module crg_apb_regs (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [crg_pkg::AddrW-1:0] paddr,
  input  logic [crg_pkg::DataW-1:0] pwdata,
  output logic [crg_pkg::DataW-1:0] prdata,
  output logic                     pready,
  output crg_pkg::cfg_t            cfg_o
);
  import crg_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[AddrW-1:2]);
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        RegCenterX: cfg_d.center_x     = pwdata[CtrW-1:0];
        RegCenterY: cfg_d.center_y     = pwdata[CtrW-1:0];
        RegRadius:  cfg_d.radius       = pwdata[RadW-1:0];
        RegWidth:   cfg_d.image_width  = pwdata[DimW-1:0];
        RegHeight:  cfg_d.image_height = pwdata[DimW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegCenterX: prdata = DataW'(cfg_q.center_x);
      RegCenterY: prdata = DataW'(cfg_q.center_y);
      RegRadius:  prdata = DataW'(cfg_q.radius);
      RegWidth:   prdata = DataW'(cfg_q.image_width);
      RegHeight:  prdata = DataW'(cfg_q.image_height);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.center_x     <= '0;
      cfg_q.center_y     <= '0;
      cfg_q.radius       <= '0;
      cfg_q.image_width  <= DimW'(256);
      cfg_q.image_height <= DimW'(192);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/crg_pipe.sv
// ----------------------------------------------------------------------------
// crg_pipe
// Three-stage pixel pipeline: distance test against the circle and luma mix.
// ----------------------------------------------------------------------------
module crg_pipe (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [crg_pkg::PixW-1:0]  pixel_i,
  input  logic [crg_pkg::ColW-1:0]  col_i,
  input  logic [crg_pkg::RowW-1:0]  row_i,
  input  crg_pkg::cfg_t             cfg_i,
  output logic                      valid_o,
  output logic [crg_pkg::PixW-1:0]  pixel_o,
  output logic                      inside_o
);
  import crg_pkg::*;

  // stage 1: pixel and distance magnitudes
  logic               v1_q;
  logic [PixW-1:0]    pix1_q;
  logic [CtrW-1:0]    adx_q, ady_q, adx_d, ady_d;
  // stage 2: squares and weighted sum
  logic               v2_q;
  logic [PixW-1:0]    pix2_q;
  logic [DistW-1:0]   dist_q, dist_d;
  logic [RadSqW-1:0]  rsq_q, rsq_d;
  logic [SumW-1:0]    sum_q, sum_d;
  // stage 3: result
  logic               v3_q;
  logic [PixW-1:0]    pix3_q, pix3_d;
  logic               in3_q, in3_d;
  logic [ProdW-1:0]   prod;
  logic [ChanW-1:0]   gray;

  always_comb begin
    if (cfg_i.center_x >= CtrW'(col_i)) adx_d = cfg_i.center_x - CtrW'(col_i);
    else                                adx_d = CtrW'(col_i) - cfg_i.center_x;
    if (cfg_i.center_y >= CtrW'(row_i)) ady_d = cfg_i.center_y - CtrW'(row_i);
    else                                ady_d = CtrW'(row_i) - cfg_i.center_y;
  end

  always_comb begin
    dist_d = DistW'(DistW'(adx_q) * DistW'(adx_q)) + DistW'(DistW'(ady_q) * DistW'(ady_q));
    rsq_d  = RadSqW'(cfg_i.radius) * RadSqW'(cfg_i.radius);
    sum_d  = SumW'(pix1_q[ChanW-1:0])         * SumW'(WeightR)
           + SumW'(pix1_q[2*ChanW-1:ChanW])   * SumW'(WeightG)
           + SumW'(pix1_q[3*ChanW-1:2*ChanW]) * SumW'(WeightB);
  end

  always_comb begin
    prod  = ProdW'(sum_q) * ProdW'(Recip);
    gray  = prod[RecipSh+ChanW-1:RecipSh];
    in3_d = ({1'b0, dist_q} <= rsq_q);
    if (in3_d) pix3_d = {gray, gray, gray};
    else       pix3_d = pix2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pix1_q <= pixel_i;
      adx_q  <= adx_d;
      ady_q  <= ady_d;
      pix2_q <= pix1_q;
      dist_q <= dist_d;
      rsq_q  <= rsq_d;
      sum_q  <= sum_d;
      pix3_q <= pix3_d;
      in3_q  <= in3_d;
    end
  end

  assign valid_o  = v3_q;
  assign pixel_o  = pix3_q;
  assign inside_o = in3_q;

endmodule

// File: rtl/circle_region_grayscale.sv
// ----------------------------------------------------------------------------
// circle_region_grayscale
// Raster-order RGB stream; pixels inside a configured circle turn to luma gray.
// ----------------------------------------------------------------------------
//  port group   dir  contents
//  s_axis_*     in   pixel stream, tdata = red, green, blue
//  m_axis_*     out  pixel stream, tdata = red, green, blue; tuser = inside flag
//  apb (p*)     both centre, radius, frame width and height registers
//
//  one pixel per clock while the output is not stalled; each pixel passes through
//  the input, arithmetic and output registers of the pipeline.
//  a stalled output holds the whole pipeline; s_axis_tready is m_axis_tready or an idle output.
//  reset clears valid flags, col/row counters, centre, radius; frame resets to 256x192.
// ----------------------------------------------------------------------------
module circle_region_grayscale (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [23:0]               s_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [23:0]               m_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
  output logic                      m_axis_tuser,   // inside_res
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [crg_pkg::AddrW-1:0] paddr,
  input  logic [crg_pkg::DataW-1:0] pwdata,
  output logic [crg_pkg::DataW-1:0] prdata,
  output logic                      pready
);
  import crg_pkg::*;

  cfg_t            cfg;
  logic            en, acc;
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic [DimW:0]   w_lim, h_lim;

  crg_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign acc           = s_axis_tvalid && en;

  assign w_lim = clamp_dim(cfg.image_width,  (DimW+1)'(MaxWidth));
  assign h_lim = clamp_dim(cfg.image_height, (DimW+1)'(MaxHeight));

  // counters past a shrunk limit wrap on their next advance
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (acc) begin
      if ((DimW+1)'(col_q) + (DimW+1)'(1) >= w_lim) begin
        col_d = '0;
        if ((DimW+1)'(row_q) + (DimW+1)'(1) >= h_lim) row_d = '0;
        else                                         row_d = row_q + RowW'(1);
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  crg_pipe u_pipe (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (acc),
    .pixel_i  (s_axis_tdata),
    .col_i    (col_q),
    .row_i    (row_q),
    .cfg_i    (cfg),
    .valid_o  (m_axis_tvalid),
    .pixel_o  (m_axis_tdata),
    .inside_o (m_axis_tuser)
  );

endmodule
